### src/dpbm_pkg.sv
// Package for the dual-port byte memory: item types, size codes and address helpers.
// Depends on nothing; used by dual_port_byte_memory.
package dpbm_pkg;

  // Memory geometry: four byte-wide banks, one byte lane each.
  localparam int MEM_BYTES = 4096;
  localparam int LANES     = 4;
  localparam int ROWS      = (MEM_BYTES + LANES - 1) / LANES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Access size codes; every other code is a word.
  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;

  localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  typedef struct packed {
    logic        fetch_enable;
    logic [31:0] fetch_address;
    logic        load_enable;
    logic        store_enable;
    logic [2:0]  access_size;
    logic [31:0] data_address;
    logic [31:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] fetched_word;
    logic        fetch_fault;
    logic [31:0] loaded_value;
    logic        data_fault;
    logic        both_enabled_warning;
  } out_item_t;

  // Number of bytes touched by an access of the given size code.
  function automatic logic [2:0] byte_count(input logic [2:0] size);
    logic [2:0] cnt;
    case (size)
      SIZE_BYTE: cnt = 3'd1;
      SIZE_HALF: cnt = 3'd2;
      default:   cnt = 3'd4;
    endcase
    return cnt;
  endfunction

  // Row of a bank lane for an access starting at addr. Lanes below the
  // starting lane hold the bytes that spill into the next row.
  function automatic logic [ROW_W-1:0] row_of(input logic [31:0] addr,
                                               input logic [1:0]  lane);
    logic [ROW_W-1:0] r;
    r = addr[ROW_W+1:2];
    if (lane < addr[1:0]) begin
      r = r + ROW_W'(1);
    end
    return r;
  endfunction

endpackage

### src/dpbm_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module dpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; the data register holds while its enable is low.
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### src/dual_port_byte_memory.sv
// Dual-port byte memory top level: fetch port and data port over four byte-lane banks.
// Depends on dpbm_pkg and dpbm_ram.
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------
//   input   | in_valid, in_ready, in_data    | in_item_t
//   result  | out_valid, out_ready, out_data | out_item_t
//
// Each item is read from the banks in the accept cycle, and the registered
// read data forms the result in the busy state, when the store bytes are
// also written. A waiting result holds the block in its busy state.
// After reset a clearing pass writes zero to one row of all banks per cycle,
// through all ROWS = MEM_BYTES/4 rounded up rows (1024 here), with in_ready low.
module dual_port_byte_memory
  import dpbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [ROW_W-1:0] clr_row_r, clr_row_nxt;
  in_item_t         in_r;
  out_item_t        out_r;
  logic             out_valid_r;
  logic [31:0]      held_r;

  logic             in_fire;
  logic             done;

  logic             bank_we    [LANES];
  logic [ROW_W-1:0] bank_waddr [LANES];
  logic [7:0]       bank_wdata [LANES];
  logic [ROW_W-1:0] fetch_row  [LANES];
  logic [ROW_W-1:0] data_row   [LANES];
  logic [7:0]       fetch_byte [LANES];
  logic [7:0]       data_byte  [LANES];

  logic [2:0]       cnt;
  logic             fetch_fault;
  logic             data_fault;
  logic             data_req;
  logic [31:0]      fetch_word;
  logic [31:0]      read_word;
  logic [31:0]      load_word;
  logic [31:0]      held_nxt;
  out_item_t        res;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign done      = (state_r == ST_BUSY) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Read rows for both ports come straight from the incoming item.
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      fetch_row[b] = row_of(in_data.fetch_address, 2'(b));
      data_row[b]  = row_of(in_data.data_address, 2'(b));
    end
  end

  // Four byte-lane banks.
  for (genvar g = 0; g < LANES; g++) begin : g_bank
    dpbm_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk     (clk),
      .we      (bank_we[g]),
      .waddr   (bank_waddr[g]),
      .wdata   (bank_wdata[g]),
      .re_a    (in_fire),
      .raddr_a (fetch_row[g]),
      .rdata_a (fetch_byte[g]),
      .re_b    (in_fire),
      .raddr_b (data_row[g]),
      .rdata_b (data_byte[g])
    );
  end

  // Bounds checks on the last byte touched, without wraparound.
  always_comb begin
    cnt         = byte_count(in_r.access_size);
    data_req    = in_r.load_enable || in_r.store_enable;
    fetch_fault = in_r.fetch_enable &&
                  (({1'b0, in_r.fetch_address} + 33'd3) >= 33'(MEM_BYTES));
    data_fault  = data_req &&
                  (({1'b0, in_r.data_address} + 33'(cnt - 3'd1)) >= 33'(MEM_BYTES));
  end

  // Gather little-endian words from the lanes.
  always_comb begin
    logic [1:0] lane;
    fetch_word = '0;
    read_word  = '0;
    for (int k = 0; k < LANES; k++) begin
      lane = in_r.fetch_address[1:0] + 2'(k);
      fetch_word[8*k +: 8] = fetch_byte[lane];
      lane = in_r.data_address[1:0] + 2'(k);
      read_word[8*k +: 8]  = data_byte[lane];
    end
  end

  // Result and held load value.
  always_comb begin
    case (in_r.access_size)
      SIZE_BYTE: load_word = read_word & BYTE_MASK;
      SIZE_HALF: load_word = read_word & HALF_MASK;
      default:   load_word = read_word;
    endcase
    if (!data_req || data_fault) begin
      held_nxt = '0;
    end else if (in_r.store_enable) begin
      held_nxt = held_r;
    end else begin
      held_nxt = load_word;
    end
    res.fetched_word         = (in_r.fetch_enable && !fetch_fault) ? fetch_word : '0;
    res.fetch_fault          = fetch_fault;
    res.loaded_value         = held_nxt;
    res.data_fault           = data_fault;
    res.both_enabled_warning = in_r.load_enable && in_r.store_enable && !data_fault;
  end

  // Bank writes: zero rows during the clearing pass, store bytes at item end.
  always_comb begin
    logic [1:0] k;
    for (int b = 0; b < LANES; b++) begin
      k = 2'(b) - in_r.data_address[1:0];
      if (state_r == ST_CLEAR) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = clr_row_r;
        bank_wdata[b] = '0;
      end else begin
        bank_we[b]    = done && in_r.store_enable && !data_fault && ({1'b0, k} < cnt);
        bank_waddr[b] = row_of(in_r.data_address, 2'(b));
        bank_wdata[b] = in_r.store_value[8*k +: 8];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
        held_r      <= held_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (done) begin
      out_r <= res;
    end
  end

`ifndef ASSERT_OFF
  // An accepted item moves the block into its busy state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_BUSY) && !in_ready)
    else $error("accepted item did not start its second cycle");

  // A finished item always presents a result.
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid)
    else $error("finished item left no result");

  // A faulting fetch never returns data.
  a_fetch_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fetch_fault) |-> (out_data.fetched_word == 32'd0))
    else $error("faulting fetch returned data");

  // The warning and the data fault exclude each other.
  a_warn_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.both_enabled_warning && out_data.data_fault))
    else $error("warning raised on a faulting access");
`endif

endmodule
